// ----- rtl/core/u2da_pkg.sv -----
// Shared types and constants for the unsigned to decimal ASCII unit.
package u2da_pkg;

    localparam int VALUE_W    = 16;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 5;
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    // Divide by ten: q = (v * RECIP) >> RECIP_SHIFT, exact for all 16-bit v
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = VALUE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 17'd52429;

    localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;
    localparam logic [CHAR_W-1:0] DIGIT_TOP  = 6'd57;
    localparam logic [IDX_W-1:0]  LAST_STEP  = IDX_W'(MAX_DIGITS - 1);

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic step_last;
        logic idx_zero;
    } t_status;

endpackage

// ----- rtl/core/u2da_datapath.sv -----
// Datapath: divide-by-ten step, digit store and character output registers.
module u2da_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  u2da_pkg::t_cmd                    i_cmd,
    input  logic [u2da_pkg::VALUE_W-1:0]      i_value,
    output u2da_pkg::t_status                 o_status,
    output logic [u2da_pkg::CHAR_W-1:0]       o_digit_char,
    output logic                              o_last,
    output logic                              o_strobe
);

    logic [u2da_pkg::VALUE_W-1:0] r_num;
    logic [u2da_pkg::DIGIT_W-1:0] r_digits [u2da_pkg::MAX_DIGITS];
    logic [u2da_pkg::IDX_W-1:0]   r_step;
    logic [u2da_pkg::IDX_W-1:0]   r_idx;
    logic [u2da_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;
    logic                         r_strobe;

    logic [u2da_pkg::PROD_W-1:0]  w_prod;
    logic [u2da_pkg::VALUE_W-1:0] w_quot;
    logic [u2da_pkg::VALUE_W-1:0] w_rem;

    always_comb begin
        w_prod = {{u2da_pkg::RECIP_W{1'b0}}, r_num}
               * {{u2da_pkg::VALUE_W{1'b0}}, u2da_pkg::RECIP};
        w_quot = u2da_pkg::VALUE_W'(w_prod >> u2da_pkg::RECIP_SHIFT);
        w_rem  = r_num - (w_quot << 3) - (w_quot << 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num  <= i_value;
            r_step <= '0;
        end else if (i_cmd.step) begin
            r_num             <= w_quot;
            r_digits[r_step]  <= w_rem[u2da_pkg::DIGIT_W-1:0];
            r_step            <= r_step + 1'b1;
            if ((r_num != '0) || (r_step == '0)) begin
                r_idx <= r_step;
            end
        end else if (i_cmd.emit) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.emit) begin
            r_char <= u2da_pkg::DIGIT_BASE
                    + {{(u2da_pkg::CHAR_W-u2da_pkg::DIGIT_W){1'b0}}, r_digits[r_idx]};
            r_last <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    assign o_status.step_last = (r_step == u2da_pkg::LAST_STEP);
    assign o_status.idx_zero  = (r_idx == '0);
    assign o_digit_char       = r_char;
    assign o_last             = r_last;
    assign o_strobe           = r_strobe;

    a_digits_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_last) |=> r_strobe)
        else $error("digit stream broken before last digit");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ((r_char >= u2da_pkg::DIGIT_BASE) && (r_char <= u2da_pkg::DIGIT_TOP)))
        else $error("character outside decimal digit range");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> !r_strobe)
        else $error("digit emitted right after a new request");

endmodule

// ----- rtl/core/u2da_ctrl.sv -----
// Controller: sequences load, conversion steps and digit emission.
module u2da_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  u2da_pkg::t_status i_status,
    output u2da_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.step_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.idx_zero) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ----- rtl/core/unsigned_to_decimal_ascii_unit.sv -----
// Top level of the unsigned to decimal ASCII unit.
// A request is taken when start is high and busy is low. The value is divided
// by ten once a cycle, one reciprocal multiply per step and one step for each
// possible digit; then its digits leave most significant first, one per cycle
// on o_strobe, with leading zeros dropped and o_last on the final digit; zero
// gives one '0'. Busy stays high through the division steps and the digit
// emission, and the next request can be taken in the first cycle with busy
// low. The receiver cannot stall: every strobe must be taken as it comes, and
// the final digit appears in the first cycle with busy low.
module unsigned_to_decimal_ascii_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [u2da_pkg::VALUE_W-1:0]  i_value,
    output logic [u2da_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                          o_last,
    output logic                          o_strobe
);

    u2da_pkg::t_cmd    w_cmd;
    u2da_pkg::t_status w_status;

    u2da_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    u2da_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_value      (i_value),
        .o_status     (w_status),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_strobe     (o_strobe)
    );

endmodule
